### rtl/core/ppc_pkg.sv
// Shared types and constants for the pedal position plausibility check.
package ppc_pkg;

   // Converter sample and calibration width.
   localparam int ADC_BITS = 10;
   // Full pedal travel in travel units.
   localparam int FULL_TRAVEL = 255;
   // Torque per travel unit.
   localparam int TORQUE_SCALE = 1;
   localparam int SCALE_W = 8;
   // Numerator magnitude width: |raw - min| * 255.
   localparam int NUM_W = ADC_BITS + 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_BITS = 2 * ADC_BITS + 2;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 38;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_LEFT_MIN        = 3'd0,
      CFG_LEFT_MAX        = 3'd1,
      CFG_RIGHT_MIN       = 3'd2,
      CFG_RIGHT_MAX       = 3'd3,
      CFG_DEVIATION_LIMIT = 3'd4,
      CFG_BRAKE_TRIP      = 3'd5,
      CFG_BRAKE_RELEASE   = 3'd6,
      CFG_FAULT_TIMEOUT   = 3'd7
   } cfg_index_type;

   typedef enum logic [2:0] {
      STATUS_IDLE      = 3'd0,
      STATUS_RUN       = 3'd1,
      STATUS_RANGE     = 3'd2,
      STATUS_DEVIATION = 3'd3,
      STATUS_BRAKE     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_LEFT,
      BK_DIV_RIGHT,
      BK_CHECK
   } back_state_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] left_min;
      logic [ADC_BITS-1:0] left_max;
      logic [ADC_BITS-1:0] right_min;
      logic [ADC_BITS-1:0] right_max;
      logic [7:0]          deviation_limit;
      logic [7:0]          brake_trip_level;
      logic [7:0]          brake_release_level;
      logic [15:0]         fault_timeout_ticks;
   } cfg_type;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic                drive_ready;
      logic                brake_applied;
      logic [ADC_BITS-1:0] raw_right;
      logic [ADC_BITS-1:0] raw_left;
   } req_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic        inverter_enable_bit;
      logic        brake_fault;
      logic        deviation_fault;
      logic        range_fault;
      status_type  status_code;
      logic [7:0]  right_travel;
      logic [7:0]  left_travel;
      logic [14:0] torque_cmd;
   } rsp_type;

   // One sensor after classification: signed numerator split into magnitude and sign.
   typedef struct packed {
      logic [NUM_W-1:0]    num_mag;
      logic                neg;
      logic [ADC_BITS-1:0] den;
      logic                bad;
   } sensor_job_type;

   typedef struct packed {
      sensor_job_type left;
      sensor_job_type right;
      logic           brake_applied;
      logic           drive_ready;
   } job_type;

   // Divider handshake toward the back end.
   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
      logic             rem_nonzero;
   } div_result_type;

endpackage

### rtl/core/pedal_position_plausibility_check.sv
// Top level of the pedal position plausibility check.
// Each request carries two raw pedal samples with the brake and drive-ready levels and
// yields exactly one result: both travels mapped to 0..255, the range, deviation and
// brake faults, a status code and the torque command. An accepted request is dequeued,
// divided for each sensor in the shared restoring divider (18 quotient bits), one sensor
// after the other, and then checked; the back end takes a new request only once the last
// one has passed its checks, and the checks wait while a result is stalled. A two-entry
// queue decouples request acceptance from processing, and the result register lets the
// next request be processed while a result waits to be taken. The user must write the
// calibration registers through the csr port only while no request is in flight; the
// block does not enforce this. csr_ready is always high.
module pedal_position_plausibility_check
   import ppc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Requests: raw_left[9:0], raw_right[19:10], brake_applied[20], drive_ready[21].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Results: torque_cmd[14:0], left_travel[22:15], right_travel[30:23],
   // status_code[33:31], range_fault[34], deviation_fault[35], brake_fault[36],
   // inverter_enable_bit[37].
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Register writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   job_type pop_data;
   logic    pop;
   logic    empty;

   assign csr_ready = 1'b1;

   // Register file write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (cfg_index_type'(csr_index))
            CFG_LEFT_MIN:        cfg_in.left_min            = csr_wdata[ADC_BITS-1:0];
            CFG_LEFT_MAX:        cfg_in.left_max            = csr_wdata[ADC_BITS-1:0];
            CFG_RIGHT_MIN:       cfg_in.right_min           = csr_wdata[ADC_BITS-1:0];
            CFG_RIGHT_MAX:       cfg_in.right_max           = csr_wdata[ADC_BITS-1:0];
            CFG_DEVIATION_LIMIT: cfg_in.deviation_limit     = csr_wdata[7:0];
            CFG_BRAKE_TRIP:      cfg_in.brake_trip_level    = csr_wdata[7:0];
            CFG_BRAKE_RELEASE:   cfg_in.brake_release_level = csr_wdata[7:0];
            CFG_FAULT_TIMEOUT:   cfg_in.fault_timeout_ticks = csr_wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_min            <= '0;
         cfg_ff.left_max            <= '1;
         cfg_ff.right_min           <= '0;
         cfg_ff.right_max           <= '1;
         cfg_ff.deviation_limit     <= 8'd25;
         cfg_ff.brake_trip_level    <= 8'd64;
         cfg_ff.brake_release_level <= 8'd13;
         cfg_ff.fault_timeout_ticks <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .pop_data   (pop_data),
      .empty      (empty)
   );

   ppc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_data   (pop_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/ppc_queue.sv
// Two-entry queue that carries classified requests from the front to the back end.
module ppc_queue
   import ppc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/ppc_front.sv
// Front end: accepts requests, classifies each sensor and queues the work.
module ppc_front
   import ppc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   pop,
   output job_type                pop_data,
   output logic                   empty
);

   req_type req;
   job_type job;
   logic    full;
   logic    push;

   assign req        = req_type'(req_tdata[REQ_BITS-1:0]);
   assign req_tready = !full;
   assign push       = req_tvalid && req_tready;

   // Split (raw - min) * 255 into sign and magnitude and flag an empty or inverted calibration.
   function automatic sensor_job_type classify(
      input logic [ADC_BITS-1:0] raw,
      input logic [ADC_BITS-1:0] lo,
      input logic [ADC_BITS-1:0] hi
   );
      sensor_job_type        s;
      logic [ADC_BITS:0]     diff;
      logic [ADC_BITS-1:0]   mag;
      diff      = {1'b0, raw} - {1'b0, lo};
      mag       = diff[ADC_BITS] ? ADC_BITS'(-diff) : diff[ADC_BITS-1:0];
      s.neg     = diff[ADC_BITS];
      s.num_mag = {mag, 8'd0} - NUM_W'(mag);
      s.den     = hi - lo;
      s.bad     = (hi <= lo);
      return s;
   endfunction

   always_comb begin
      job.left          = classify(req.raw_left, cfg.left_min, cfg.left_max);
      job.right         = classify(req.raw_right, cfg.right_min, cfg.right_max);
      job.brake_applied = req.brake_applied;
      job.drive_ready   = req.drive_ready;
   end

   ppc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

endmodule

### rtl/core/ppc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both sensors.
module ppc_divider
   import ppc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    dividend,
   input  logic [ADC_BITS-1:0] divisor,
   output div_result_type      result
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ADC_BITS-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [ADC_BITS-1:0] div_ff, div_in;
   logic [ADC_BITS:0]   trial;
   logic                take;

   // One shift-and-subtract step per cycle.
   always_comb begin
      trial    = {rem_ff, quo_ff[NUM_W-1]};
      take     = (trial >= {1'b0, div_ff});
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         count_in = CNT_W'(NUM_W);
         busy_in  = 1'b1;
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = take ? ADC_BITS'(trial - {1'b0, div_ff}) : trial[ADC_BITS-1:0];
         quo_in   = {quo_ff[NUM_W-2:0], take};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign result.done        = done_ff;
   assign result.quotient    = quo_ff;
   assign result.rem_nonzero = (rem_ff != '0);

endmodule

### rtl/core/ppc_back.sv
// Back end: sequences the divisions, runs the plausibility checks and holds the result.
module ppc_back
   import ppc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  job_type                pop_data,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   back_state_type       state_ff, state_in;
   job_type              job_ff, job_in;
   logic signed [15:0]   tl_ff, tl_in;
   logic signed [15:0]   tr_ff, tr_in;
   logic                 latch_ff, latch_in;
   logic [15:0]          fault_cnt_ff, fault_cnt_in;
   logic [14:0]          held_ff, held_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 div_start;
   logic [NUM_W-1:0]     div_dividend;
   logic [ADC_BITS-1:0]  div_divisor;
   div_result_type       div_res;
   logic signed [15:0]   travel;
   logic                 cur_neg;
   logic                 cur_bad;

   // Check stage signals.
   logic signed [15:0]   pmin, pmax;
   logic signed [16:0]   spread;
   logic                 oor_l, oor_r, range_f, dev_f, latch_next;
   logic [7:0]           cl, cr;
   logic [15:0]          cnt_plus;
   logic [15:0]          torque_prod;
   logic                 out_free;
   status_type           status;

   ppc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // Floor the signed quotient and saturate it to 16 bits; an empty or inverted calibration reads 0.
   function automatic logic signed [15:0] floor_sat(
      input logic [NUM_W-1:0] qmag,
      input logic             rem_nz,
      input logic             neg,
      input logic             bad
   );
      logic [NUM_W:0]     qup;
      logic signed [15:0] v;
      qup = {1'b0, qmag} + (NUM_W + 1)'(neg && rem_nz);
      if (bad) begin
         v = 16'sd0;
      end else if (!neg) begin
         v = (qmag > NUM_W'(32767)) ? 16'sh7FFF : 16'(qmag);
      end else begin
         v = (qup > (NUM_W + 1)'(32768)) ? 16'sh8000 : 16'(-qup);
      end
      return v;
   endfunction

   assign cur_neg = (state_ff == BK_DIV_LEFT) ? job_ff.left.neg : job_ff.right.neg;
   assign cur_bad = (state_ff == BK_DIV_LEFT) ? job_ff.left.bad : job_ff.right.bad;
   assign travel  = floor_sat(div_res.quotient, div_res.rem_nonzero, cur_neg, cur_bad);

   // Plausibility checks on the saturated travels.
   always_comb begin
      pmin     = (tl_ff < tr_ff) ? tl_ff : tr_ff;
      pmax     = (tl_ff > tr_ff) ? tl_ff : tr_ff;
      spread   = {pmax[15], pmax} - {pmin[15], pmin};
      dev_f    = (spread > $signed({9'd0, cfg.deviation_limit}));
      oor_l    = job_ff.left.bad || (tl_ff < 16'sd0) || (tl_ff > 16'(FULL_TRAVEL));
      oor_r    = job_ff.right.bad || (tr_ff < 16'sd0) || (tr_ff > 16'(FULL_TRAVEL));
      range_f  = oor_l || oor_r;
      cl       = (tl_ff < 16'sd0) ? 8'd0 : ((tl_ff > 16'(FULL_TRAVEL)) ? 8'd255 : tl_ff[7:0]);
      cr       = (tr_ff < 16'sd0) ? 8'd0 : ((tr_ff > 16'(FULL_TRAVEL)) ? 8'd255 : tr_ff[7:0]);
      cnt_plus = fault_cnt_ff + 16'd1;
      torque_prod = pmin[7:0] * SCALE_W'(TORQUE_SCALE);
      if (job_ff.brake_applied && (pmin >= $signed({8'd0, cfg.brake_trip_level}))) begin
         latch_next = 1'b1;
      end else if (latch_ff && (pmin <= $signed({8'd0, cfg.brake_release_level}))) begin
         latch_next = 1'b0;
      end else begin
         latch_next = latch_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer, state update and result register.
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      tl_in        = tl_ff;
      tr_in        = tr_ff;
      latch_in     = latch_ff;
      fault_cnt_in = fault_cnt_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = pop_data.left.num_mag;
      div_divisor  = pop_data.left.den;
      status       = STATUS_IDLE;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               job_in    = pop_data;
               div_start = 1'b1;
               state_in  = BK_DIV_LEFT;
            end
         end
         BK_DIV_LEFT: begin
            div_dividend = job_ff.right.num_mag;
            div_divisor  = job_ff.right.den;
            if (div_res.done) begin
               tl_in     = travel;
               div_start = 1'b1;
               state_in  = BK_DIV_RIGHT;
            end
         end
         BK_DIV_RIGHT: begin
            if (div_res.done) begin
               tr_in    = travel;
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            if (out_free) begin
               latch_in = latch_next;
               if (latch_next) begin
                  held_in = '0;
                  status  = STATUS_BRAKE;
               end else if (!job_ff.drive_ready) begin
                  held_in = '0;
                  status  = STATUS_IDLE;
               end else if (range_f || dev_f) begin
                  status = range_f ? STATUS_RANGE : STATUS_DEVIATION;
                  if (cnt_plus >= cfg.fault_timeout_ticks) begin
                     held_in      = '0;
                     fault_cnt_in = '0;
                  end else begin
                     fault_cnt_in = cnt_plus;
                  end
               end else begin
                  status       = STATUS_RUN;
                  fault_cnt_in = '0;
                  held_in      = torque_prod[14:0];
               end
               rsp_in.torque_cmd          = held_in;
               rsp_in.left_travel         = cl;
               rsp_in.right_travel        = cr;
               rsp_in.status_code         = status;
               rsp_in.range_fault         = range_f;
               rsp_in.deviation_fault     = dev_f;
               rsp_in.brake_fault         = latch_next;
               rsp_in.inverter_enable_bit = !job_ff.drive_ready;
               rsp_valid_in               = 1'b1;
               state_in                   = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         latch_ff     <= 1'b0;
         fault_cnt_ff <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         latch_ff     <= latch_in;
         fault_cnt_ff <= fault_cnt_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      tl_ff  <= tl_in;
      tr_ff  <= tr_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_BITS)'(0), rsp_ff};

endmodule

### rtl/core/ppc_checker.sv
// Port-level checks for the pedal position plausibility check, bound to the top level.
module ppc_checker
   import ppc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_type rsp;

   assign rsp = rsp_type'(rsp_tdata[RSP_BITS-1:0]);

   // A stalled result keeps its value until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Brake status always comes with the brake fault bit set and zero torque.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status_code == STATUS_BRAKE)
         |-> rsp.brake_fault && (rsp.torque_cmd == '0))
      else $error("brake status without zero torque");

   // Drive mode off means zero torque and the inverter bit set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status_code == STATUS_IDLE)
         |-> rsp.inverter_enable_bit && (rsp.torque_cmd == '0))
      else $error("idle status with torque or inverter bit clear");

   // Run status only when no fault is flagged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status_code == STATUS_RUN)
         |-> !rsp.range_fault && !rsp.deviation_fault && !rsp.brake_fault)
      else $error("run status with a fault flagged");

endmodule

bind pedal_position_plausibility_check ppc_checker u_checker (.*);

### tb/sv/tb_pedal_position_plausibility_check.sv
// Self-checking testbench for the pedal position plausibility check.
`timescale 1ns / 1ps

module tb_pedal_position_plausibility_check;
   import ppc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int CHUNK_ITEMS    = 50;
   localparam int CHUNKS_PER_PHASE = 3;

   typedef enum int {
      CAL_TYPICAL,
      CAL_WIDE_STRICT,
      CAL_NARROW_LOOSE
   } calib_flavor_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // raw_left[9:0], raw_right[19:10], brake_applied[20], drive_ready[21].
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   // torque_cmd[14:0], left_travel[22:15], right_travel[30:23], status_code[33:31],
   // range_fault[34], deviation_fault[35], brake_fault[36], inverter_enable_bit[37].
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the calibration and of the block state.
   cfg_type     calib;
   logic        latch_set;
   logic [15:0] fault_ticks;
   logic [14:0] torque_hold;

   rsp_type expected_responses[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      idle_cycles = 0;
   int      chunk_serial = 0;

   // Pedal walk used by the random traffic.
   int   pedal_travel = 0;
   logic brake_level = 1'b0;
   logic ready_level = 1'b1;

   pedal_position_plausibility_check DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Any accepted transfer restarts the watchdog.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_pedal_position_plausibility_check: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic model_reset();
      calib.left_min            = 10'd0;
      calib.left_max            = 10'd1023;
      calib.right_min           = 10'd0;
      calib.right_max           = 10'd1023;
      calib.deviation_limit     = 8'd25;
      calib.brake_trip_level    = 8'd64;
      calib.brake_release_level = 8'd13;
      calib.fault_timeout_ticks = 16'd100;
      latch_set   = 1'b0;
      fault_ticks = '0;
      torque_hold = '0;
   endtask

   // Travel floor((raw - lo) * 255 / (hi - lo)) saturated to 16 signed bits.
   function automatic int travel_of(logic [ADC_BITS-1:0] raw, logic [ADC_BITS-1:0] lo,
                                    logic [ADC_BITS-1:0] hi, output logic bad);
      int num;
      int den;
      int q;
      if (hi <= lo) begin
         bad = 1'b1;
         return 0;
      end
      bad = 1'b0;
      num = (int'(raw) - int'(lo)) * FULL_TRAVEL;
      den = int'(hi) - int'(lo);
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic int clamp_travel(int t);
      if (t < 0) return 0;
      if (t > FULL_TRAVEL) return FULL_TRAVEL;
      return t;
   endfunction

   // Expected response for one accepted request; advances the predictor state.
   function automatic rsp_type predict_pedal_response(req_type item);
      int      tl;
      int      tr;
      int      pmin;
      int      pmax;
      logic    bad_l;
      logic    bad_r;
      logic    range_f;
      logic    dev_f;
      rsp_type res;
      tl = travel_of(item.raw_left, calib.left_min, calib.left_max, bad_l);
      tr = travel_of(item.raw_right, calib.right_min, calib.right_max, bad_r);
      pmin = (tl < tr) ? tl : tr;
      pmax = (tl > tr) ? tl : tr;
      range_f = bad_l || tl < 0 || tl > FULL_TRAVEL || bad_r || tr < 0 || tr > FULL_TRAVEL;
      dev_f = (pmax - pmin) > int'(calib.deviation_limit);

      // Latch sets on braking with high travel and holds down to the release level.
      if (item.brake_applied && pmin >= int'(calib.brake_trip_level)) begin
         latch_set = 1'b1;
      end else if (latch_set && pmin <= int'(calib.brake_release_level)) begin
         latch_set = 1'b0;
      end

      if (latch_set) begin
         torque_hold = '0;
         res.status_code = STATUS_BRAKE;
      end else if (!item.drive_ready) begin
         torque_hold = '0;
         res.status_code = STATUS_IDLE;
      end else if (range_f || dev_f) begin
         res.status_code = range_f ? STATUS_RANGE : STATUS_DEVIATION;
         fault_ticks = fault_ticks + 16'd1;
         if (fault_ticks >= calib.fault_timeout_ticks) begin
            torque_hold = '0;
            fault_ticks = '0;
         end
      end else begin
         res.status_code = STATUS_RUN;
         fault_ticks = '0;
         torque_hold = 15'(pmin * TORQUE_SCALE);
      end

      res.torque_cmd          = torque_hold;
      res.left_travel         = 8'(clamp_travel(tl));
      res.right_travel        = 8'(clamp_travel(tr));
      res.range_fault         = range_f;
      res.deviation_fault     = dev_f;
      res.brake_fault         = latch_set;
      res.inverter_enable_bit = ~item.drive_ready;
      return res;
   endfunction

   task automatic check_response(rsp_type want, rsp_type got);
      if (got.torque_cmd !== want.torque_cmd) begin
         $error("torque_cmd: expected %0d, actual %0d", want.torque_cmd,
                got.torque_cmd);
         error_count++;
      end
      if (got.left_travel !== want.left_travel) begin
         $error("left_travel: expected %0d, actual %0d", want.left_travel, got.left_travel);
         error_count++;
      end
      if (got.right_travel !== want.right_travel) begin
         $error("right_travel: expected %0d, actual %0d", want.right_travel,
                got.right_travel);
         error_count++;
      end
      if (got.status_code !== want.status_code) begin
         $error("status_code: expected %0d, actual %0d", want.status_code, got.status_code);
         error_count++;
      end
      if (got.range_fault !== want.range_fault) begin
         $error("range_fault: expected %0d, actual %0d", want.range_fault, got.range_fault);
         error_count++;
      end
      if (got.deviation_fault !== want.deviation_fault) begin
         $error("deviation_fault: expected %0d, actual %0d", want.deviation_fault,
                got.deviation_fault);
         error_count++;
      end
      if (got.brake_fault !== want.brake_fault) begin
         $error("brake_fault: expected %0d, actual %0d", want.brake_fault, got.brake_fault);
         error_count++;
      end
      if (got.inverter_enable_bit !== want.inverter_enable_bit) begin
         $error("inverter_enable_bit: expected %0d, actual %0d", want.inverter_enable_bit,
                got.inverter_enable_bit);
         error_count++;
      end
   endtask

   // Each accepted response is matched against the oldest expectation.
   always @(posedge clock) begin : response_checker
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            check_response(expected_responses.pop_front(), got);
         end
      end
   end

   // Sends one request and records its predicted response on acceptance.
   task automatic send_pedal_sample(logic [ADC_BITS-1:0] raw_l, logic [ADC_BITS-1:0] raw_r,
                                    logic brake, logic ready);
      req_type item;
      item.raw_left      = raw_l;
      item.raw_right     = raw_r;
      item.brake_applied = brake;
      item.drive_ready   = ready;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-REQ_BITS){1'b0}}, item};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_responses.push_back(predict_pedal_response(item));
   endtask

   // Waits until every outstanding request has produced its response.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(cfg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CFG_LEFT_MIN:        calib.left_min = value[ADC_BITS-1:0];
         CFG_LEFT_MAX:        calib.left_max = value[ADC_BITS-1:0];
         CFG_RIGHT_MIN:       calib.right_min = value[ADC_BITS-1:0];
         CFG_RIGHT_MAX:       calib.right_max = value[ADC_BITS-1:0];
         CFG_DEVIATION_LIMIT: calib.deviation_limit = value[7:0];
         CFG_BRAKE_TRIP:      calib.brake_trip_level = value[7:0];
         CFG_BRAKE_RELEASE:   calib.brake_release_level = value[7:0];
         CFG_FAULT_TIMEOUT:   calib.fault_timeout_ticks = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_calibration(int lmin, int lmax, int rmin, int rmax, int dev_limit,
                                    int trip, int release_level, int timeout_ticks);
      write_register(CFG_LEFT_MIN, 16'(lmin));
      write_register(CFG_LEFT_MAX, 16'(lmax));
      write_register(CFG_RIGHT_MIN, 16'(rmin));
      write_register(CFG_RIGHT_MAX, 16'(rmax));
      write_register(CFG_DEVIATION_LIMIT, 16'(dev_limit));
      write_register(CFG_BRAKE_TRIP, 16'(trip));
      write_register(CFG_BRAKE_RELEASE, 16'(release_level));
      write_register(CFG_FAULT_TIMEOUT, 16'(timeout_ticks));
   endtask

   // Reset calibration: zero and full travel, drive mode off, sensor disagreement.
   task automatic test_reset_calibration();
      send_pedal_sample(10'd0, 10'd0, 1'b0, 1'b1);
      send_pedal_sample(10'd1023, 10'd1023, 1'b0, 1'b1);
      send_pedal_sample(10'd512, 10'd512, 1'b0, 1'b0);
      send_pedal_sample(10'd1023, 10'd0, 1'b0, 1'b1);
   endtask

   // Travel below zero, above full, empty calibration and 16-bit saturation.
   task automatic test_calibration_edges();
      drain_responses();
      write_calibration(100, 900, 100, 900, 25, 64, 13, 100);
      send_pedal_sample(10'd50, 10'd50, 1'b0, 1'b1);
      send_pedal_sample(10'd1023, 10'd1023, 1'b0, 1'b1);
      drain_responses();
      write_register(CFG_LEFT_MAX, 16'd100);
      send_pedal_sample(10'd500, 10'd500, 1'b0, 1'b1);
      drain_responses();
      write_calibration(0, 1, 1022, 1023, 25, 64, 13, 100);
      send_pedal_sample(10'd1023, 10'd0, 1'b0, 1'b1);
      drain_responses();
      write_calibration(0, 1023, 0, 1023, 25, 64, 13, 100);
   endtask

   // The brake latch holds, also with the brake released, until travel falls to the release level.
   task automatic test_brake_hysteresis();
      send_pedal_sample(10'd400, 10'd400, 1'b1, 1'b1);
      send_pedal_sample(10'd400, 10'd400, 1'b0, 1'b1);
      send_pedal_sample(10'd100, 10'd100, 1'b1, 1'b1);
      send_pedal_sample(10'd40, 10'd40, 1'b1, 1'b1);
      send_pedal_sample(10'd300, 10'd300, 1'b1, 1'b1);
      send_pedal_sample(10'd0, 10'd0, 1'b0, 1'b1);
   endtask

   // Torque is held through a persisting fault, then zeroed at the timeout.
   task automatic test_fault_timeout();
      drain_responses();
      write_register(CFG_FAULT_TIMEOUT, 16'd3);
      send_pedal_sample(10'd800, 10'd800, 1'b0, 1'b1);
      repeat (3) send_pedal_sample(10'd800, 10'd200, 1'b0, 1'b1);
      send_pedal_sample(10'd800, 10'd800, 1'b0, 1'b1);
      drain_responses();
      // A zero timeout drops the torque on the first faulty tick.
      write_register(CFG_FAULT_TIMEOUT, 16'd0);
      send_pedal_sample(10'd1023, 10'd0, 1'b0, 1'b1);
      drain_responses();
      write_register(CFG_DEVIATION_LIMIT, 16'd255);
      send_pedal_sample(10'd1023, 10'd0, 1'b0, 1'b1);
   endtask

   task automatic load_random_calibration(calib_flavor_type flavor);
      int lmin;
      int lmax;
      int rmin;
      int rmax;
      int trip;
      drain_responses();
      case (flavor)
         CAL_WIDE_STRICT:  write_calibration(0, 1023, 0, 1023, 0, 0, 0, 1);
         CAL_NARROW_LOOSE: write_calibration(1022, 1023, 0, 1023, 255, 255, 255, 65535);
         default: begin
            lmin = $urandom_range(400);
            lmax = $urandom_range(1023, 600);
            rmin = $urandom_range(400);
            rmax = $urandom_range(1023, 600);
            // Now and then one sensor gets an empty or inverted calibration.
            if ($urandom_range(7) == 0) rmax = rmin;
            if ($urandom_range(7) == 0) lmax = $urandom_range(lmin);
            trip = $urandom_range(200, 20);
            write_calibration(lmin, lmax, rmin, rmax, $urandom_range(60, 5), trip,
                              $urandom_range(trip), $urandom_range(12, 1));
         end
      endcase
   endtask

   function automatic logic [ADC_BITS-1:0] raw_for_travel(int travel, logic [ADC_BITS-1:0] lo,
                                                         logic [ADC_BITS-1:0] hi);
      int v;
      if (hi <= lo) return ADC_BITS'($urandom_range(1023));
      v = int'(lo) + (travel * (int'(hi) - int'(lo))) / FULL_TRAVEL;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return ADC_BITS'(v);
   endfunction

   // Mostly a plausible pedal walk with matched sensors, with some raw noise mixed in.
   task automatic send_pedal_walk(int count);
      int skew;
      repeat (count) begin
         if ($urandom_range(99) < 15) begin
            send_pedal_sample(ADC_BITS'($urandom_range(1023)), ADC_BITS'($urandom_range(1023)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            pedal_travel = pedal_travel + $urandom_range(40) - 20;
            if (pedal_travel < -8) pedal_travel = -8;
            if (pedal_travel > 263) pedal_travel = 263;
            if ($urandom_range(99) < 8) brake_level = ~brake_level;
            if ($urandom_range(99) < 3) ready_level = ~ready_level;
            skew = ($urandom_range(99) < 10) ? $urandom_range(80) - 40 : $urandom_range(4) - 2;
            send_pedal_sample(raw_for_travel(pedal_travel, calib.left_min, calib.left_max),
                              raw_for_travel(pedal_travel + skew, calib.right_min,
                                             calib.right_max),
                              brake_level, ready_level);
         end
      end
   endtask

   task automatic run_random_phase(int idle_pct, int stall_level);
      send_idle_pct = idle_pct;
      stall_pct     = stall_level;
      repeat (CHUNKS_PER_PHASE) begin
         case (chunk_serial % 4)
            1:       load_random_calibration(CAL_WIDE_STRICT);
            3:       load_random_calibration(CAL_NARROW_LOOSE);
            default: load_random_calibration(CAL_TYPICAL);
         endcase
         chunk_serial++;
         send_pedal_walk(CHUNK_ITEMS);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0);
      run_random_phase(86, 0);
      run_random_phase(0, 86);
      run_random_phase(20, 20);
   endtask

   initial begin
      model_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_calibration();
      test_calibration_edges();
      test_brake_hysteresis();
      test_fault_timeout();
      test_random_traffic();
      drain_responses();
      if (error_count == 0) begin
         $display("tb_pedal_position_plausibility_check: done, clean");
      end else begin
         $display("tb_pedal_position_plausibility_check: done, errors");
      end
      $finish;
   end

endmodule
